// ----- hw/rtl/pdc_pkg.sv -----
// Shared constants and types for the Porter-Duff pixel compositor.
package pdc_pkg;

  localparam int CHANNELS       = 4;
  localparam int COEF_BITS      = 16;
  localparam int MODE_BITS      = 3;
  localparam int CFG_INDEX_BITS = 3;
  localparam int STAGES         = 3;

  // Channel order inside one pixel beat
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_ALPHA = 3;

  // Operator codes
  localparam logic [MODE_BITS-1:0] MODE_OVER    = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_IN      = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_OUT     = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_ATOP    = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_XOR     = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_LIGHTER = 3'd5;
  localparam logic [MODE_BITS-1:0] MODE_ARITH   = 3'd6;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PRODUCT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEST    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET  = 3'd4;

  typedef struct packed {
    logic        [MODE_BITS-1:0] mode;
    logic signed [COEF_BITS-1:0] coef_product;
    logic signed [COEF_BITS-1:0] coef_source;
    logic signed [COEF_BITS-1:0] coef_dest;
    logic signed [COEF_BITS-1:0] coef_offset;
  } cfg_t;

  typedef struct packed {
    logic [STAGES-1:0] load;
  } stage_ctl_t;

endpackage

// ----- hw/rtl/pdc_pixel_if.sv -----
// Input channel: one source and one destination RGBA pixel per beat.
interface pdc_pixel_if #(parameter int CHANNEL_BITS = 8) ();
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] src_red;
  logic [CHANNEL_BITS-1:0] src_green;
  logic [CHANNEL_BITS-1:0] src_blue;
  logic [CHANNEL_BITS-1:0] src_alpha;
  logic [CHANNEL_BITS-1:0] dst_red;
  logic [CHANNEL_BITS-1:0] dst_green;
  logic [CHANNEL_BITS-1:0] dst_blue;
  logic [CHANNEL_BITS-1:0] dst_alpha;

  modport source (
    output valid, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue, dst_alpha,
    input  ready
  );
  modport sink (
    input  valid, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue, dst_alpha,
    output ready
  );
endinterface

// ----- hw/rtl/pdc_result_if.sv -----
// Output channel: one composited RGBA pixel per beat.
interface pdc_result_if #(parameter int CHANNEL_BITS = 8) ();
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] out_red;
  logic [CHANNEL_BITS-1:0] out_green;
  logic [CHANNEL_BITS-1:0] out_blue;
  logic [CHANNEL_BITS-1:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

// ----- hw/rtl/pdc_cfg_if.sv -----
// Configuration write channel: register index and data per beat.
interface pdc_cfg_if ();
  import pdc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [COEF_BITS-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/pdc_cfg_regs.sv -----
// Configuration register file: operator mode and arithmetic coefficients.
module pdc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  pdc_cfg_if.sink       cfg,
  output pdc_pkg::cfg_t regs
);
  import pdc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode         <= MODE_OVER;
      regs.coef_product <= '0;
      regs.coef_source  <= '0;
      regs.coef_dest    <= '0;
      regs.coef_offset  <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MODE:    regs.mode         <= cfg.data[MODE_BITS-1:0];
        REG_PRODUCT: regs.coef_product <= $signed(cfg.data);
        REG_SOURCE:  regs.coef_source  <= $signed(cfg.data);
        REG_DEST:    regs.coef_dest    <= $signed(cfg.data);
        REG_OFFSET:  regs.coef_offset  <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/pdc_lane.sv -----
// One channel lane: three-stage multiply / sum / round datapath plus clamp.
module pdc_lane #(
  parameter int CHANNEL_BITS   = 8,
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic                    clk,
  input  pdc_pkg::cfg_t           cfg,
  input  pdc_pkg::stage_ctl_t     ctl,
  input  logic [CHANNEL_BITS-1:0] s,
  input  logic [CHANNEL_BITS-1:0] d,
  input  logic [CHANNEL_BITS-1:0] sa,
  input  logic [CHANNEL_BITS-1:0] da,
  output logic [CHANNEL_BITS-1:0] q
);
  import pdc_pkg::*;

  localparam int N  = CHANNEL_BITS;
  localparam int F  = COEF_FRAC_BITS;
  localparam int PW = COEF_BITS + N + 1;      // coef times channel
  localparam int TW = PW + N + 1;             // coef times channel times channel
  localparam int W  = 2 * N + COEF_BITS + 4;  // full arithmetic numerator

  localparam logic [N-1:0]        CH_MAX   = '1;
  localparam logic signed [W-1:0] CH_MAX_W = $signed({{(W-N){1'b0}}, CH_MAX});
  localparam logic signed [W-1:0] ROUND_PD = CH_MAX_W >>> 1;
  localparam logic signed [W-1:0] ROUND_AR = CH_MAX_W <<< (F - 1);
  localparam logic signed [W-1:0] LIMIT    = CH_MAX_W <<< N;

  // stage 1
  logic [N-1:0]           rsa, rda, fa, fb;
  logic [2*N-1:0]         prod_a, prod_b;
  logic signed [PW-1:0]   k1s, k2s, k3d;
  logic [N-1:0]           d1;
  // stage 2
  logic signed [W-1:0]    lin_w, k4w, lin_off_next;
  logic signed [TW-1:0]   t1;
  logic [2*N:0]           pd_sum;
  logic signed [W-1:0]    lin_off;
  // stage 3
  logic signed [W-1:0]    num_ar, y_ar, y_pd, y_next, y;
  // output
  logic [2*N-1:0]         yy;
  logic [2*N:0]           qt;

  always_comb begin
    rsa = CH_MAX - sa;
    rda = CH_MAX - da;
    case (cfg.mode)
      MODE_IN:      begin fa = da;     fb = '0;     end
      MODE_OUT:     begin fa = rda;    fb = '0;     end
      MODE_ATOP:    begin fa = da;     fb = rsa;    end
      MODE_XOR:     begin fa = rda;    fb = rsa;    end
      MODE_LIGHTER: begin fa = CH_MAX; fb = CH_MAX; end
      MODE_OVER:    begin fa = CH_MAX; fb = rsa;    end
      default:      begin fa = CH_MAX; fb = rsa;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      prod_a <= s * fa;
      prod_b <= d * fb;
      k1s    <= $signed(cfg.coef_product) * $signed({1'b0, s});
      k2s    <= $signed(cfg.coef_source) * $signed({1'b0, s});
      k3d    <= $signed(cfg.coef_dest) * $signed({1'b0, d});
      d1     <= d;
    end
  end

  // (k2*s + k3*d)*M + k4*M*M, times M done as shift and subtract
  always_comb begin
    lin_w        = W'(k2s) + W'(k3d);
    k4w          = W'(cfg.coef_offset);
    lin_off_next = (lin_w <<< N) - lin_w
                 + (k4w <<< (2 * N)) - (k4w <<< (N + 1)) + k4w;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      t1      <= k1s * $signed({1'b0, d1});
      pd_sum  <= {1'b0, prod_a} + {1'b0, prod_b};
      lin_off <= lin_off_next;
    end
  end

  // y = round-half-up numerator already divided by the power-of-two part
  always_comb begin
    num_ar = W'(t1) + lin_off;
    y_ar   = (num_ar + ROUND_AR) >>> F;
    y_pd   = $signed({{(W-2*N-1){1'b0}}, pd_sum}) + ROUND_PD;
    y_next = (cfg.mode == MODE_ARITH) ? y_ar : y_pd;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      y <= y_next;
    end
  end

  // floor(y / M) with M = 2^N - 1, exact for y < M * 2^N
  always_comb begin
    yy = y[2*N-1:0];
    qt = {1'b0, yy} + {{(N+1){1'b0}}, yy[2*N-1:N]} + (2*N+1)'(1);
    if (y[W-1]) begin
      q = '0;
    end else if (y >= LIMIT) begin
      q = CH_MAX;
    end else begin
      q = qt[2*N-1:N];
    end
  end

endmodule

// ----- hw/rtl/pdc_merge.sv -----
// Merge stage: stage valid chain, output register packing the four lanes.
module pdc_merge #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  output pdc_pkg::stage_ctl_t       ctl,
  input  logic [CHANNEL_BITS-1:0]   lane_q [pdc_pkg::CHANNELS],
  pdc_result_if.source              result
);
  import pdc_pkg::*;

  logic [STAGES-1:0]       stage_valid;
  logic [STAGES-1:0]       load;
  logic                    out_valid;
  logic                    out_load;
  logic [CHANNEL_BITS-1:0] out_q [CHANNELS];

  // each stage moves when it is empty or the one after it moves
  always_comb begin
    out_load = !out_valid || result.ready;
    load[STAGES-1] = !stage_valid[STAGES-1] || out_load;
    for (int i = STAGES - 2; i >= 0; i--) begin
      load[i] = !stage_valid[i] || load[i+1];
    end
    ctl.load = load;
    in_ready = load[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (load[0]) stage_valid[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) begin
        if (load[i]) stage_valid[i] <= stage_valid[i-1];
      end
      if (out_load) out_valid <= stage_valid[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && stage_valid[STAGES-1]) begin
      out_q <= lane_q;
    end
  end

  assign result.valid     = out_valid;
  assign result.out_red   = out_q[CH_RED];
  assign result.out_green = out_q[CH_GREEN];
  assign result.out_blue  = out_q[CH_BLUE];
  assign result.out_alpha = out_q[CH_ALPHA];

endmodule

// ----- hw/rtl/porter_duff_pixel_compositor.sv -----
// Top level of the Porter-Duff / arithmetic pixel compositor.
//
//   channel  dir  beat contents
//   -------  ---  ------------------------------------------------
//   pixel    in   src_red/green/blue/alpha, dst_red/green/blue/alpha
//   result   out  out_red/green/blue/alpha
//   cfg      in   index, data (mode, k1, k2, k3, k4)
//
// One pixel per clock while result is ready; four lanes (R, G, B, A) run in parallel.
// Registered steps in order: multiply, product/sum, round, output register.
// Each pipeline stage stalls only when full and blocked downstream, so
// bubbles are squeezed out while result is stalled. cfg is always ready.
// Synchronous reset clears the valid chain and the cfg registers; no clearing pass.
module porter_duff_pixel_compositor #(
  parameter int CHANNEL_BITS   = 8,
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  pdc_pixel_if.sink    pixel,
  pdc_result_if.source result,
  pdc_cfg_if.sink      cfg
);
  import pdc_pkg::*;

  cfg_t                    regs;
  stage_ctl_t              ctl;
  logic [CHANNEL_BITS-1:0] src_ch [CHANNELS];
  logic [CHANNEL_BITS-1:0] dst_ch [CHANNELS];
  logic [CHANNEL_BITS-1:0] lane_q [CHANNELS];

  always_comb begin
    src_ch[CH_RED]   = pixel.src_red;
    src_ch[CH_GREEN] = pixel.src_green;
    src_ch[CH_BLUE]  = pixel.src_blue;
    src_ch[CH_ALPHA] = pixel.src_alpha;
    dst_ch[CH_RED]   = pixel.dst_red;
    dst_ch[CH_GREEN] = pixel.dst_green;
    dst_ch[CH_BLUE]  = pixel.dst_blue;
    dst_ch[CH_ALPHA] = pixel.dst_alpha;
  end

  pdc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    pdc_lane #(
      .CHANNEL_BITS   (CHANNEL_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .cfg (regs),
      .ctl (ctl),
      .s   (src_ch[c]),
      .d   (dst_ch[c]),
      .sa  (pixel.src_alpha),
      .da  (pixel.dst_alpha),
      .q   (lane_q[c])
    );
  end

  pdc_merge #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel.valid),
    .in_ready (pixel.ready),
    .ctl      (ctl),
    .lane_q   (lane_q),
    .result   (result)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the Porter-Duff / arithmetic pixel compositor.
`timescale 1ns / 1ps

module testbench;
  import pdc_pkg::*;

  localparam int     CW          = 8;
  localparam int     COEF_FRAC   = 8;
  localparam longint FULL_SCALE  = (64'd1 << CW) - 1;
  localparam int     CYCLE_LIMIT = 300000;

  // Code 7 has no operator of its own and must act as over
  localparam logic [MODE_BITS-1:0] MODE_SPARE = 3'd7;

  localparam logic signed [COEF_BITS-1:0] COEF_ONE = 16'sd256;
  localparam logic signed [COEF_BITS-1:0] COEF_MAX = 16'sh7fff;
  localparam logic signed [COEF_BITS-1:0] COEF_MIN = 16'sh8000;

  typedef logic [CHANNELS-1:0][CW-1:0] rgba_t;
  typedef struct packed {
    rgba_t src;
    rgba_t dst;
  } pixel_pair_t;

  logic clk;
  logic rst;

  pdc_pixel_if #(.CHANNEL_BITS(CW)) pixel_bus ();
  pdc_result_if #(.CHANNEL_BITS(CW)) result_bus ();
  pdc_cfg_if cfg_bus ();

  porter_duff_pixel_compositor #(
    .CHANNEL_BITS  (CW),
    .COEF_FRAC_BITS(COEF_FRAC)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel_bus),
    .result(result_bus),
    .cfg   (cfg_bus)
  );

  // Shadow copy of the register file
  logic        [MODE_BITS-1:0] cur_mode;
  logic signed [COEF_BITS-1:0] k_prod;
  logic signed [COEF_BITS-1:0] k_src;
  logic signed [COEF_BITS-1:0] k_dst;
  logic signed [COEF_BITS-1:0] k_off;

  rgba_t pending_pixels[$];
  int    fail_count = 0;
  int    cycle_count = 0;
  int    burst_left;
  bit    steady_sender;
  int    stall_left = 0;
  string lane_name[CHANNELS] = '{"red", "green", "blue", "alpha"};

  logic [MODE_BITS-1:0] op_codes[8] = '{MODE_OVER, MODE_IN, MODE_OUT, MODE_ATOP,
                                        MODE_XOR, MODE_LIGHTER, MODE_ARITH, MODE_SPARE};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d pixels still outstanding", $time, pending_pixels.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Output backpressure: the style rotates through four patterns as the cycle count advances
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_bus.ready <= 1'b0;
    end else begin
      case ((cycle_count >> 8) % 4)
        0: result_bus.ready <= 1'b1;
        1: result_bus.ready <= ($urandom_range(0, 3) != 0);
        2: result_bus.ready <= ((cycle_count % 7) > 1);
        default: begin
          if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(4, 24);
          result_bus.ready <= (stall_left == 0);
        end
      endcase
    end
  end

  function automatic logic [CW-1:0] blend_channel(input logic [CW-1:0] s, d, sa, da);
    longint full, ls, ld, lsa, lda, num, den, q;
    longint lk1, lk2, lk3, lk4;
    full = FULL_SCALE;
    ls   = s;
    ld   = d;
    lsa  = sa;
    lda  = da;
    lk1  = k_prod;
    lk2  = k_src;
    lk3  = k_dst;
    lk4  = k_off;
    den  = full;
    case (cur_mode)
      MODE_IN:      num = ls * lda;
      MODE_OUT:     num = ls * (full - lda);
      MODE_ATOP:    num = ls * lda + ld * (full - lsa);
      MODE_XOR:     num = ls * (full - lda) + ld * (full - lsa);
      MODE_LIGHTER: num = (ls + ld) * full;
      MODE_ARITH: begin
        num = lk1 * ls * ld + lk2 * ls * full + lk3 * ld * full + lk4 * full * full;
        den = full << COEF_FRAC;
      end
      default:      num = ls * full + ld * (full - lsa);
    endcase
    // round half up, then saturate
    if (num <= 0) begin
      q = 0;
    end else begin
      q = (2 * num + den) / (2 * den);
      if (q > full) q = full;
    end
    return q[CW-1:0];
  endfunction

  function automatic rgba_t composite_pixel(input pixel_pair_t px);
    rgba_t res;
    for (int c = 0; c < CHANNELS; c++) begin
      res[c] = blend_channel(px.src[c], px.dst[c], px.src[CH_ALPHA], px.dst[CH_ALPHA]);
    end
    return res;
  endfunction

  function automatic void store_setting(input logic [CFG_INDEX_BITS-1:0] idx,
                                        input logic [COEF_BITS-1:0] value);
    case (idx)
      REG_MODE:    cur_mode = value[MODE_BITS-1:0];
      REG_PRODUCT: k_prod = value;
      REG_SOURCE:  k_src = value;
      REG_DEST:    k_dst = value;
      REG_OFFSET:  k_off = value;
      default: ;
    endcase
  endfunction

  function automatic pixel_pair_t pair(input logic [CW-1:0] sr, sg, sb, sa,
                                       input logic [CW-1:0] dr, dg, db, da);
    pixel_pair_t px;
    px.src = {sa, sb, sg, sr};
    px.dst = {da, db, dg, dr};
    return px;
  endfunction

  function automatic logic [COEF_BITS-1:0] random_coef();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 64) - 32 + ($urandom_range(0, 1) ? 256 : -256);
      1: v = $urandom_range(0, 1024) - 512;
      2: v = $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0: v = COEF_MAX;
          1: v = COEF_MIN;
          2: v = 0;
          default: v = COEF_ONE;
        endcase
      end
    endcase
    return v[COEF_BITS-1:0];
  endfunction

  // Mostly well-formed premultiplied pixels, some raw noise, some rail values
  function automatic pixel_pair_t random_pixel();
    pixel_pair_t px;
    int kind;
    kind = $urandom_range(0, 9);
    px.src = $urandom;
    px.dst = $urandom;
    if (kind < 7) begin
      for (int c = 0; c < CH_ALPHA; c++) begin
        px.src[c] = CW'($urandom_range(0, px.src[CH_ALPHA]));
        px.dst[c] = CW'($urandom_range(0, px.dst[CH_ALPHA]));
      end
    end else if (kind == 9) begin
      for (int c = 0; c < CHANNELS; c++) begin
        px.src[c] = $urandom_range(0, 1) ? '1 : '0;
        px.dst[c] = $urandom_range(0, 1) ? '1 : '0;
      end
    end
    return px;
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    fail_count++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    rgba_t got;
    rgba_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      got = {result_bus.out_alpha, result_bus.out_blue, result_bus.out_green, result_bus.out_red};
      if (pending_pixels.size() == 0) begin
        note_mismatch("unexpected result beat", -1, got);
      end else begin
        want = pending_pixels.pop_front();
        for (int c = 0; c < CHANNELS; c++) begin
          if (got[c] !== want[c]) note_mismatch({"out_", lane_name[c]}, want[c], got[c]);
        end
      end
    end
  end

  task automatic send_pixel(input pixel_pair_t px);
    int gap;
    if (burst_left == 0) begin
      burst_left = steady_sender ? 64 : $urandom_range(1, 12);
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        pixel_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pixel_bus.valid     <= 1'b1;
    pixel_bus.src_red   <= px.src[CH_RED];
    pixel_bus.src_green <= px.src[CH_GREEN];
    pixel_bus.src_blue  <= px.src[CH_BLUE];
    pixel_bus.src_alpha <= px.src[CH_ALPHA];
    pixel_bus.dst_red   <= px.dst[CH_RED];
    pixel_bus.dst_green <= px.dst[CH_GREEN];
    pixel_bus.dst_blue  <= px.dst[CH_BLUE];
    pixel_bus.dst_alpha <= px.dst[CH_ALPHA];
    do @(posedge clk); while (!pixel_bus.ready);
    pending_pixels.push_back(composite_pixel(px));
  endtask

  task automatic wait_drained();
    pixel_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  // Leaves valid high so back-to-back writes stream; callers release the channel
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [COEF_BITS-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    store_setting(idx, value);
  endtask

  task automatic program_regs(input logic [MODE_BITS-1:0] mode,
                              input logic [COEF_BITS-1:0] k1, k2, k3, k4);
    logic [COEF_BITS-1:0] mode_word;
    mode_word = COEF_BITS'($urandom);  // junk above the mode field must be ignored
    mode_word[MODE_BITS-1:0] = mode;
    write_reg(REG_MODE, mode_word);
    write_reg(REG_PRODUCT, k1);
    write_reg(REG_SOURCE, k2);
    write_reg(REG_DEST, k3);
    write_reg(REG_OFFSET, k4);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_pixel(pair(255, 0, 128, 128, 0, 255, 64, 255));
    send_pixel(pair(0, 0, 0, 0, 255, 255, 255, 255));
    wait_drained();
  endtask

  task automatic test_operators();
    for (int m = 0; m < 8; m++) begin
      program_regs(op_codes[m], COEF_ONE, 16'd0, 16'd0, 16'd0);
      send_pixel(pair(255, 0, 255, 0, 0, 255, 255, 255));
      send_pixel(pair(60, 120, 30, 128, 200, 100, 90, 200));
      wait_drained();
    end
  endtask

  task automatic test_arith_clamps();
    // negative sum saturates at zero
    program_regs(MODE_ARITH, 16'd0, -COEF_ONE, 16'd0, 16'd0);
    send_pixel(pair(60, 120, 30, 128, 200, 100, 90, 200));
    wait_drained();
    program_regs(MODE_ARITH, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_pixel(pair(255, 255, 255, 255, 255, 255, 255, 255));
    wait_drained();
    program_regs(MODE_ARITH, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_pixel(pair(255, 0, 255, 0, 0, 255, 255, 255));
    wait_drained();
    // fractional weights exercise rounding
    program_regs(MODE_ARITH, COEF_ONE / 2, COEF_ONE / 2, -COEF_ONE / 4, 16'd1);
    send_pixel(pair(60, 120, 30, 128, 200, 100, 90, 200));
    wait_drained();
  endtask

  task automatic test_register_decode();
    program_regs(MODE_ARITH, COEF_ONE, COEF_ONE / 2, -COEF_ONE / 2, 16'd0);
    send_pixel(pair(60, 120, 30, 128, 200, 100, 90, 200));
    wait_drained();
    // writes past the last register must not disturb anything
    for (int idx = REG_OFFSET + 1; idx < (1 << CFG_INDEX_BITS); idx++) begin
      write_reg(idx[CFG_INDEX_BITS-1:0], COEF_BITS'($urandom));
    end
    cfg_bus.valid <= 1'b0;
    send_pixel(pair(60, 120, 30, 128, 200, 100, 90, 200));
    wait_drained();
    write_reg(REG_MODE, {{(COEF_BITS - MODE_BITS){1'b1}}, MODE_IN});
    cfg_bus.valid <= 1'b0;
    send_pixel(pair(255, 40, 0, 200, 10, 255, 99, 77));
    wait_drained();
  endtask

  task automatic test_random_stream();
    logic [MODE_BITS-1:0] mode;
    for (int phase = 0; phase < 12; phase++) begin
      mode = (phase < 8) ? op_codes[phase] : MODE_ARITH;
      steady_sender = (phase % 4 == 3);
      burst_left = 0;
      if (phase == 8) begin
        program_regs(mode, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      end else if (phase == 9) begin
        program_regs(mode, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      end else begin
        program_regs(mode, random_coef(), random_coef(), random_coef(), random_coef());
      end
      repeat (80) send_pixel(random_pixel());
      wait_drained();
    end
    steady_sender = 1'b0;
  endtask

  initial begin
    int idle;
    rst                 = 1'b1;
    pixel_bus.valid     = 1'b0;
    pixel_bus.src_red   = '0;
    pixel_bus.src_green = '0;
    pixel_bus.src_blue  = '0;
    pixel_bus.src_alpha = '0;
    pixel_bus.dst_red   = '0;
    pixel_bus.dst_green = '0;
    pixel_bus.dst_blue  = '0;
    pixel_bus.dst_alpha = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = REG_MODE;
    cfg_bus.data        = '0;
    cur_mode            = MODE_OVER;
    k_prod              = '0;
    k_src               = '0;
    k_dst               = '0;
    k_off               = '0;
    burst_left          = 0;
    steady_sender       = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_operators();
    test_arith_clamps();
    test_register_decode();
    test_random_stream();

    idle = 0;
    while (pending_pixels.size() != 0 && idle < 2000) begin
      @(posedge clk);
      idle++;
    end
    repeat (2 * STAGES + 4) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      note_mismatch("results never delivered", 0, pending_pixels.size());
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_pixel_if.sv
hw/rtl/pdc_result_if.sv
hw/rtl/pdc_cfg_if.sv
hw/rtl/pdc_cfg_regs.sv
hw/rtl/pdc_lane.sv
hw/rtl/pdc_merge.sv
hw/rtl/porter_duff_pixel_compositor.sv
tb/testbench.sv
